// ----- rtl/wsfrp_pkg.sv -----
// Shared types, result and error codes, and header constants of the WebSocket frame parser.
package wsfrp_pkg;

    typedef enum logic [1:0] {
        PH_HDR0 = 2'd0,
        PH_HDR1 = 2'd1,
        PH_EXT  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    localparam logic [1:0] RK_DATA = 2'd0;
    localparam logic [1:0] RK_DONE = 2'd1;
    localparam logic [1:0] RK_ERR  = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_FINAL  = 3'd1;
    localparam logic [2:0] ERR_MASKED    = 3'd2;
    localparam logic [2:0] ERR_OPCODE    = 3'd3;
    localparam logic [2:0] ERR_CTRL_FRAG = 3'd4;
    localparam logic [2:0] ERR_CTRL_LONG = 3'd5;
    localparam logic [2:0] ERR_TRUNC     = 3'd6;

    localparam logic [6:0]  LEN_CODE16 = 7'd126;
    localparam logic [63:0] CTRL_MAX   = 64'd125;
    localparam logic [3:0]  EXT_LEN16  = 4'd2;
    localparam logic [3:0]  EXT_LEN64  = 4'd8;
    localparam int          CTRL_BIT   = 3;

    localparam logic REG_EXPECT_FINAL    = 1'b0;
    localparam logic REG_EXPECTED_OPCODE = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [3:0]  opcode;
        logic [63:0] length;
        logic [2:0]  err;
    } result_t;

endpackage

// ----- rtl/wsfrp_parse.sv -----
// Header decoding, frame checks and payload counting, one stream byte per request.
module wsfrp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              kind,
    input  logic [7:0]        rx_byte,
    input  logic              expect_final,
    input  logic [3:0]        expected_opcode,
    output logic              res_valid,
    output wsfrp_pkg::result_t res
);
    import wsfrp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  ext_left_reg, ext_left_next;
    logic [63:0] accum_reg, accum_next;
    logic [63:0] payload_left_reg, payload_left_next;
    logic        final_reg, final_next;
    logic [3:0]  opcode_reg, opcode_next;

    logic        len_done;
    logic [63:0] len_val;
    logic [63:0] pl_dec;
    logic [6:0]  code;

    always_comb
    begin
        phase_next        = phase_reg;
        ext_left_next     = ext_left_reg;
        accum_next        = accum_reg;
        payload_left_next = payload_left_reg;
        final_next        = final_reg;
        opcode_next       = opcode_reg;
        res_valid         = 1'b0;
        res.kind          = RK_DATA;
        res.data          = 8'd0;
        res.last          = 1'b0;
        res.opcode        = opcode_reg;
        res.length        = 64'd0;
        res.err           = ERR_NONE;
        len_done          = 1'b0;
        len_val           = 64'd0;
        code              = rx_byte[6:0];
        pl_dec            = payload_left_reg - 64'd1;

        if (step)
        begin
            if (kind)
            begin
                if (phase_reg != PH_HDR0)
                begin
                    res_valid         = 1'b1;
                    res.kind          = RK_ERR;
                    res.err           = ERR_TRUNC;
                    res.length        = (phase_reg == PH_DATA) ? accum_reg : 64'd0;
                    phase_next        = PH_HDR0;
                    ext_left_next     = 4'd0;
                    payload_left_next = 64'd0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HDR0:
                    begin
                        final_next  = rx_byte[7];
                        opcode_next = rx_byte[3:0];
                        accum_next  = 64'd0;
                        phase_next  = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        if (expect_final && !final_reg)
                        begin
                            res.err = ERR_NO_FINAL;
                        end
                        else if (rx_byte[7])
                        begin
                            res.err = ERR_MASKED;
                        end
                        else if (opcode_reg != expected_opcode)
                        begin
                            res.err = ERR_OPCODE;
                        end
                        else if (opcode_reg[CTRL_BIT] && !final_reg)
                        begin
                            res.err = ERR_CTRL_FRAG;
                        end
                        else if (code < LEN_CODE16)
                        begin
                            len_val    = {57'd0, code};
                            accum_next = len_val;
                            len_done   = 1'b1;
                        end
                        else
                        begin
                            ext_left_next = (code == LEN_CODE16) ? EXT_LEN16 : EXT_LEN64;
                            accum_next    = 64'd0;
                            phase_next    = PH_EXT;
                        end
                        if (res.err != ERR_NONE)
                        begin
                            res_valid         = 1'b1;
                            res.kind          = RK_ERR;
                            phase_next        = PH_HDR0;
                            ext_left_next     = 4'd0;
                            payload_left_next = 64'd0;
                        end
                    end
                    PH_EXT:
                    begin
                        len_val       = {accum_reg[55:0], rx_byte};
                        accum_next    = len_val;
                        ext_left_next = ext_left_reg - 4'd1;
                        len_done      = (ext_left_reg == 4'd1);
                    end
                    PH_DATA:
                    begin
                        payload_left_next = pl_dec;
                        res_valid         = 1'b1;
                        res.kind          = RK_DATA;
                        res.data          = rx_byte;
                        res.last          = (pl_dec == 64'd0);
                        res.length        = accum_reg;
                        if (pl_dec == 64'd0)
                        begin
                            phase_next = PH_HDR0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HDR0;
                    end
                endcase

                if (len_done)
                begin
                    if (opcode_reg[CTRL_BIT] && (len_val > CTRL_MAX))
                    begin
                        res_valid         = 1'b1;
                        res.kind          = RK_ERR;
                        res.err           = ERR_CTRL_LONG;
                        res.length        = len_val;
                        phase_next        = PH_HDR0;
                        ext_left_next     = 4'd0;
                        payload_left_next = 64'd0;
                    end
                    else if (len_val == 64'd0)
                    begin
                        res_valid  = 1'b1;
                        res.kind   = RK_DONE;
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        payload_left_next = len_val;
                        phase_next        = PH_DATA;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HDR0;
            ext_left_reg     <= 4'd0;
            accum_reg        <= 64'd0;
            payload_left_reg <= 64'd0;
            final_reg        <= 1'b0;
            opcode_reg       <= 4'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            ext_left_reg     <= ext_left_next;
            accum_reg        <= accum_next;
            payload_left_reg <= payload_left_next;
            final_reg        <= final_next;
            opcode_reg       <= opcode_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXT) |-> (ext_left_reg != 4'd0))
        else $error("Extended length phase with no length bytes left.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (payload_left_reg != 64'd0))
        else $error("Payload phase with no payload bytes left.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR0) |-> (ext_left_reg == 4'd0 && payload_left_reg == 64'd0))
        else $error("Counters not cleared while waiting for a header.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !kind && phase_reg == PH_DATA) |-> res_valid)
        else $error("Payload byte produced no result.");

endmodule

// ----- rtl/websocket_frame_receive_parser_core.sv -----
// Top level of the WebSocket frame receive parser: configuration registers and result register.
//
// The input channel (in_valid, in_ready, kind, rx_byte) carries one request per received
// stream byte, or an end-of-input marker when kind is 1. The output channel (out_valid,
// out_ready, result_kind and the other result fields) carries at most one result per
// request: a payload byte, an empty-frame completion, or an error.
// A request is decoded in the cycle it is accepted and its result appears in the output
// register in the next cycle. The sustained rate is one request per clock cycle while the
// output register is free, as the parser state and 64-bit payload counter update per request.
// A request is accepted whenever the output register is empty or is being emptied in the
// same cycle, so a stalled receiver holds the input channel only while a result waits.
// Requests that give no result still need that free slot.
// Reset returns the parser to waiting for the first header byte, empties the output
// register and sets expect_final and expected_opcode to 1.
// The APB port holds expect_final at address 0 and expected_opcode at address 4; writes
// are expected only while the parser is idle.
module websocket_frame_receive_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  data_byte,
    output logic        last_byte,
    output logic [3:0]  frame_opcode,
    output logic [63:0] frame_length,
    output logic [2:0]  error_code
);
    import wsfrp_pkg::*;

    logic       expect_final_reg;
    logic [3:0] expected_opcode_reg;
    logic       cfg_write;

    logic       accept;
    logic       res_valid;
    result_t    res;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_EXPECTED_OPCODE) ? {28'd0, expected_opcode_reg}
                                                         : {31'd0, expect_final_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_final_reg    <= 1'b1;
            expected_opcode_reg <= 4'd1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_EXPECT_FINAL)
            begin
                expect_final_reg <= pwdata[0];
            end
            else
            begin
                expected_opcode_reg <= pwdata[3:0];
            end
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    wsfrp_parse u_parse (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (accept),
        .kind            (kind),
        .rx_byte         (rx_byte),
        .expect_final    (expect_final_reg),
        .expected_opcode (expected_opcode_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_reg.kind;
    assign data_byte    = out_reg.data;
    assign last_byte    = out_reg.last;
    assign frame_opcode = out_reg.opcode;
    assign frame_length = out_reg.length;
    assign error_code   = out_reg.err;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_kind == RK_DATA || result_kind == RK_DONE
                       || result_kind == RK_ERR))
        else $error("Result register holds an undefined result kind.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((result_kind == RK_ERR) == (error_code != ERR_NONE)))
        else $error("Error code does not agree with the result kind.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind != RK_DATA) |-> (data_byte == 8'd0 && !last_byte))
        else $error("Non-payload result carries payload fields.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_valid) |=> out_valid)
        else $error("Accepted result was not loaded into the result register.");

endmodule

// ----- tb/wsfrp_checker.sv -----
// Checker for the WebSocket frame receive parser: predicts every result and compares it.
module wsfrp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  result_kind,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [3:0]  frame_opcode,
    input  logic [63:0] frame_length,
    input  logic [2:0]  error_code,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import wsfrp_pkg::*;

    result_t     expected_results[$];
    int          mismatch_total = 0;
    int          waiting = 0;

    logic        cfg_final;
    logic [3:0]  cfg_opcode;

    phase_t      parse_phase;
    logic [3:0]  ext_left;
    logic [63:0] length_accum;
    logic [63:0] payload_left;
    logic        final_seen;
    logic [3:0]  cur_opcode;

    assign mismatches = mismatch_total;
    assign outstanding = waiting;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        mismatch_total++;
    endtask

    task automatic push_result(input logic [1:0] rk, input logic [7:0] data, input logic last,
                               input logic [63:0] len, input logic [2:0] err);
        result_t r;
        r.kind = rk;
        r.data = data;
        r.last = last;
        r.opcode = cur_opcode;
        r.length = len;
        r.err = err;
        expected_results.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] err, input logic [63:0] len);
        push_result(RK_ERR, 8'h00, 1'b0, len, err);
        parse_phase = PH_HDR0;
        ext_left = '0;
        payload_left = '0;
    endtask

    task automatic close_length();
        if (cur_opcode[CTRL_BIT] && length_accum > CTRL_MAX)
            raise_error(ERR_CTRL_LONG, length_accum);
        else if (length_accum == 64'd0)
        begin
            push_result(RK_DONE, 8'h00, 1'b0, 64'd0, ERR_NONE);
            parse_phase = PH_HDR0;
        end
        else
        begin
            payload_left = length_accum;
            parse_phase = PH_DATA;
        end
    endtask

    task automatic parse_request(input logic is_end, input logic [7:0] b);
        if (is_end)
        begin
            if (parse_phase != PH_HDR0)
                raise_error(ERR_TRUNC, (parse_phase == PH_DATA) ? length_accum : 64'd0);
        end
        else
        begin
            case (parse_phase)
                PH_HDR0:
                begin
                    final_seen = b[7];
                    cur_opcode = b[3:0];
                    length_accum = '0;
                    parse_phase = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (cfg_final && !final_seen)
                        raise_error(ERR_NO_FINAL, 64'd0);
                    else if (b[7])
                        raise_error(ERR_MASKED, 64'd0);
                    else if (cur_opcode != cfg_opcode)
                        raise_error(ERR_OPCODE, 64'd0);
                    else if (cur_opcode[CTRL_BIT] && !final_seen)
                        raise_error(ERR_CTRL_FRAG, 64'd0);
                    else if (b[6:0] < LEN_CODE16)
                    begin
                        length_accum = {57'd0, b[6:0]};
                        close_length();
                    end
                    else
                    begin
                        length_accum = '0;
                        ext_left = (b[6:0] == LEN_CODE16) ? EXT_LEN16 : EXT_LEN64;
                        parse_phase = PH_EXT;
                    end
                end
                PH_EXT:
                begin
                    length_accum = {length_accum[55:0], b};
                    ext_left = ext_left - 4'd1;
                    if (ext_left == 4'd0)
                        close_length();
                end
                default:
                begin
                    payload_left = payload_left - 64'd1;
                    push_result(RK_DATA, b, payload_left == 64'd0, length_accum, ERR_NONE);
                    if (payload_left == 64'd0)
                        parse_phase = PH_HDR0;
                end
            endcase
        end
    endtask

    task automatic check_result();
        result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with none expected", {62'd0, result_kind}, 64'd0);
            return;
        end
        want = expected_results.pop_front();
        if (result_kind !== want.kind)
            report_mismatch("result_kind", 64'(result_kind), 64'(want.kind));
        if (data_byte !== want.data)
            report_mismatch("data_byte", 64'(data_byte), 64'(want.data));
        if (last_byte !== want.last)
            report_mismatch("last_byte", 64'(last_byte), 64'(want.last));
        if (frame_opcode !== want.opcode)
            report_mismatch("frame_opcode", 64'(frame_opcode), 64'(want.opcode));
        if (frame_length !== want.length)
            report_mismatch("frame_length", frame_length, want.length);
        if (error_code !== want.err)
            report_mismatch("error_code", 64'(error_code), 64'(want.err));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            cfg_final = 1'b1;
            cfg_opcode = 4'd1;
            parse_phase = PH_HDR0;
            ext_left = '0;
            length_accum = '0;
            payload_left = '0;
            final_seen = 1'b0;
            cur_opcode = '0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_EXPECT_FINAL)
                    cfg_final = pwdata[0];
                else
                    cfg_opcode = pwdata[3:0];
            end
            if (in_valid && in_ready)
                parse_request(kind, rx_byte);
        end
        waiting = expected_results.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the WebSocket frame receive parser: stimulus, flow control and verdict.
module tb;
    import wsfrp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [8:0] END_MARK   = 9'h100;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [3:0]  frame_opcode;
    logic [63:0] frame_length;
    logic [2:0]  error_code;

    int          mismatches;
    int          outstanding;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          requests_sent = 0;
    logic        hold_flip = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    logic        cfg_final = 1'b1;
    logic [3:0]  cfg_opcode = 4'd1;

    always #5 clk = ~clk;

    websocket_frame_receive_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .frame_opcode (frame_opcode),
        .frame_length (frame_length),
        .error_code   (error_code)
    );

    wsfrp_checker result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .frame_opcode (frame_opcode),
        .frame_length (frame_length),
        .error_code   (error_code),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        if (hold_flip != hold_seen)
        begin
            hold_seen = hold_flip;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(input logic is_end, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= is_end;
        rx_byte <= value;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
    endtask

    task automatic send_burst(input logic [8:0] burst[$]);
        foreach (burst[i])
            send_request(burst[i][8], burst[i][7:0]);
    endtask

    task automatic settle_parser();
        send_request(1'b1, 8'($urandom));
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_parser(input logic fin, input logic [3:0] opc);
        logic [31:0] junk;
        settle_parser();
        junk = $urandom;
        junk[0] = fin;
        write_register(REG_EXPECT_FINAL, junk);
        junk = $urandom;
        junk[3:0] = opc;
        write_register(REG_EXPECTED_OPCODE, junk);
        cfg_final = fin;
        cfg_opcode = opc;
    endtask

    task automatic offer_frame();
        logic [8:0]  burst[$];
        logic        fin;
        logic [3:0]  opc;
        logic        masked;
        logic [63:0] len;
        logic [6:0]  len_code;
        logic        header_ok;
        int          pick;
        int          ext_count;
        int          nsend;
        int          n;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                burst.push_back({($urandom_range(9) == 0), 8'($urandom)});
            send_burst(burst);
            return;
        end
        fin = cfg_final ? ($urandom_range(9) != 0) : 1'($urandom);
        opc = ($urandom_range(9) < 8) ? cfg_opcode : 4'($urandom);
        masked = ($urandom_range(19) == 0);
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            len = 64'($urandom_range(0, 8));
            len_code = len[6:0];
        end
        else if (pick < 55)
        begin
            len = 64'($urandom_range(118, 125));
            len_code = len[6:0];
        end
        else if (pick < 75)
        begin
            len = ($urandom_range(3) == 0) ? 64'($urandom_range(120, 300))
                                           : 64'($urandom_range(0, 6));
            len_code = LEN_CODE16;
        end
        else if (pick < 92)
        begin
            len = 64'($urandom_range(0, 6));
            len_code = LEN_CODE64;
        end
        else
        begin
            len = {$urandom, $urandom};
            len_code = LEN_CODE64;
        end
        burst.push_back({1'b0, fin, 3'($urandom), opc});
        if ($urandom_range(32) == 0)
        begin
            burst.push_back(END_MARK);
            send_burst(burst);
            return;
        end
        burst.push_back({1'b0, masked, len_code});
        header_ok = !(cfg_final && !fin) && !masked && (opc == cfg_opcode)
                    && !(opc[CTRL_BIT] && !fin);
        if (header_ok)
        begin
            ext_count = (len_code == LEN_CODE16) ? 2 : (len_code == LEN_CODE64) ? 8 : 0;
            if (ext_count > 0 && $urandom_range(19) == 0)
            begin
                n = $urandom_range(0, ext_count - 1);
                for (int i = 0; i < n; i++)
                    burst.push_back({1'b0, len[8 * (ext_count - 1 - i) +: 8]});
                burst.push_back(END_MARK);
            end
            else
            begin
                for (int i = 0; i < ext_count; i++)
                    burst.push_back({1'b0, len[8 * (ext_count - 1 - i) +: 8]});
                if (!(opc[CTRL_BIT] && len > CTRL_MAX))
                begin
                    if (len > 64'd40)
                        nsend = $urandom_range(0, 5);
                    else if (len > 64'd0 && $urandom_range(9) == 0)
                        nsend = $urandom_range(0, int'(len) - 1);
                    else
                        nsend = int'(len);
                    repeat (nsend)
                        burst.push_back({1'b0, 8'($urandom)});
                    if (64'(nsend) != len)
                        burst.push_back(END_MARK);
                end
            end
        end
        send_burst(burst);
    endtask

    initial
    begin
        #2000000;
        $display("websocket_frame_receive_parser_core regression: fail");
        $finish;
    end

    initial
    begin
        logic [8:0] directed_a[$];
        logic [8:0] directed_b[$];
        logic       phase_final[8];
        logic [3:0] phase_opcode[8];
        int         send_pct[4];
        int         recv_pct[4];
        int         goal;
        directed_a = '{END_MARK, 9'h081, 9'h000, 9'h081, 9'h001, 9'h0FF,
                       9'h001, 9'h000, 9'h081, 9'h080, 9'h082, 9'h000,
                       9'h081, 9'h07F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
                       9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, END_MARK};
        directed_b = '{9'h008, 9'h000, 9'h088, 9'h07E, 9'h000, 9'h07E, 9'h088, 9'h000};
        phase_final = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        phase_opcode = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd9, 4'd2, 4'd10, 4'd1};
        send_pct = '{0, 77, 0, 38};
        recv_pct = '{0, 0, 77, 38};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_burst(directed_a);
        program_parser(1'b0, 4'd8);
        send_burst(directed_b);

        for (int p = 0; p < 8; p++)
        begin
            program_parser(phase_final[p], phase_opcode[p]);
            send_idle_pct = send_pct[p % 4];
            recv_stall_pct <= recv_pct[p % 4];
            if (p == 4)
                hold_flip <= ~hold_flip;
            goal = requests_sent + 50;
            while (requests_sent < goal)
                offer_frame();
        end
        settle_parser();

        if (mismatches == 0 && outstanding == 0)
            $display("websocket_frame_receive_parser_core regression: pass");
        else
            $display("websocket_frame_receive_parser_core regression: fail");
        $finish;
    end

endmodule
